// ----- hdl/tcwf_pkg.sv -----
// Shared widths, constants and beat types for the TSDF cell fusion block.
`default_nettype none

package tcwf_pkg;

    localparam int VALUE_WIDTH      = 16;
    localparam int WEIGHT_WIDTH     = 16;
    localparam int MAX_WEIGHT_WIDTH = 15;

    localparam logic [MAX_WEIGHT_WIDTH-1:0] MAX_WEIGHT_RESET = '1;

    localparam int PRODUCT_WIDTH = VALUE_WIDTH + WEIGHT_WIDTH;
    localparam int ACC_WIDTH     = PRODUCT_WIDTH + 1;
    localparam int SUM_WIDTH     = WEIGHT_WIDTH + 1;
    localparam int CMP_WIDTH     = (SUM_WIDTH > MAX_WEIGHT_WIDTH) ? SUM_WIDTH : MAX_WEIGHT_WIDTH;

    // Per-item control and pass-through results that ride along the divider
    typedef struct packed {
        logic                           avg;
        logic                           neg;
        logic [SUM_WIDTH-1:0]           divisor;
        logic signed [VALUE_WIDTH-1:0]  res_value;
        logic signed [WEIGHT_WIDTH-1:0] res_weight;
    } item_t;

    // Partial remainder, remaining dividend bits and quotient so far
    typedef struct packed {
        item_t                   meta;
        logic [SUM_WIDTH-1:0]    rem;
        logic [VALUE_WIDTH-1:0]  low;
        logic [VALUE_WIDTH-1:0]  quo;
    } div_t;

endpackage

`default_nettype wire

// ----- hdl/tcwf_in_if.sv -----
// Input channel: stored and new cell entries with valid/ready.
`default_nettype none

interface tcwf_in_if
    import tcwf_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [VALUE_WIDTH-1:0]  old_value;
    logic signed [WEIGHT_WIDTH-1:0] old_weight;
    logic signed [VALUE_WIDTH-1:0]  new_value;
    logic signed [WEIGHT_WIDTH-1:0] meas_weight;

    modport source (output valid, old_value, old_weight, new_value, meas_weight, input ready);
    modport sink   (input valid, old_value, old_weight, new_value, meas_weight, output ready);
endinterface

`default_nettype wire

// ----- hdl/tcwf_out_if.sv -----
// Output channel: fused cell entry with valid/ready.
`default_nettype none

interface tcwf_out_if
    import tcwf_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [VALUE_WIDTH-1:0]  fused_value;
    logic signed [WEIGHT_WIDTH-1:0] fused_weight;

    modport source (output valid, fused_value, fused_weight, input ready);
    modport sink   (input valid, fused_value, fused_weight, output ready);
endinterface

`default_nettype wire

// ----- hdl/tcwf_front.sv -----
// Front stages: products and case select, weighted sum, magnitude and divider setup.
`default_nettype none

module tcwf_front
    import tcwf_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    tcwf_in_if.sink                          cell_in,
    input  wire logic [MAX_WEIGHT_WIDTH-1:0] weight_limit,
    output logic                             dn_valid,
    input  wire logic                        dn_ready,
    output div_t                             dn_data
);

    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic a_ready;
    logic b_ready;
    logic c_ready;

    logic signed [PRODUCT_WIDTH-1:0] a_p0_reg;
    logic signed [PRODUCT_WIDTH-1:0] a_p1_reg;
    item_t                           a_meta_reg;
    logic signed [ACC_WIDTH-1:0]     b_acc_reg;
    item_t                           b_meta_reg;
    div_t                            c_data_reg;

    logic signed [PRODUCT_WIDTH-1:0] a_p0_next;
    logic signed [PRODUCT_WIDTH-1:0] a_p1_next;
    item_t                           a_meta_next;
    logic signed [ACC_WIDTH-1:0]     b_acc_next;
    div_t                            c_data_next;

    logic                 old_pos;
    logic                 new_pos;
    logic                 new_zero;
    logic [SUM_WIDTH-1:0] wsum;
    logic [CMP_WIDTH-1:0] wsum_ext;
    logic [CMP_WIDTH-1:0] max_ext;
    logic [CMP_WIDTH-1:0] clamped;
    logic                 replace;
    logic                 acc_neg;
    logic [ACC_WIDTH-1:0] mag_full;

    // A stage moves when its successor is empty or moving
    assign c_ready       = !c_valid_reg || dn_ready;
    assign b_ready       = !b_valid_reg || c_ready;
    assign a_ready       = !a_valid_reg || b_ready;
    assign cell_in.ready = a_ready;

    always_comb
    begin
        old_pos  = !cell_in.old_weight[WEIGHT_WIDTH-1] && (|cell_in.old_weight);
        new_pos  = !cell_in.meas_weight[WEIGHT_WIDTH-1] && (|cell_in.meas_weight);
        new_zero = !(|cell_in.meas_weight);
        replace  = !new_zero && !old_pos;
        wsum     = {1'b0, cell_in.old_weight} + {1'b0, cell_in.meas_weight};
        wsum_ext = CMP_WIDTH'(wsum);
        max_ext  = CMP_WIDTH'(weight_limit);
        clamped  = (wsum_ext > max_ext) ? max_ext : wsum_ext;

        a_p0_next = PRODUCT_WIDTH'(cell_in.old_value) * PRODUCT_WIDTH'(cell_in.old_weight);
        a_p1_next = PRODUCT_WIDTH'(cell_in.new_value) * PRODUCT_WIDTH'(cell_in.meas_weight);

        a_meta_next.avg       = old_pos && new_pos;
        a_meta_next.neg       = 1'b0;
        a_meta_next.divisor   = wsum;
        a_meta_next.res_value = replace ? cell_in.new_value : cell_in.old_value;
        if (old_pos && new_pos)
        begin
            a_meta_next.res_weight = WEIGHT_WIDTH'(clamped);
        end
        else if (replace)
        begin
            a_meta_next.res_weight = cell_in.meas_weight;
        end
        else
        begin
            a_meta_next.res_weight = cell_in.old_weight;
        end
    end

    assign b_acc_next = ACC_WIDTH'(a_p0_reg) + ACC_WIDTH'(a_p1_reg);

    // Split the sum into sign and magnitude; the top bits seed the remainder
    always_comb
    begin
        acc_neg  = b_acc_reg[ACC_WIDTH-1];
        mag_full = acc_neg ? (-b_acc_reg) : b_acc_reg;

        c_data_next          = '0;
        c_data_next.meta     = b_meta_reg;
        c_data_next.meta.neg = acc_neg;
        c_data_next.rem      = SUM_WIDTH'(mag_full[PRODUCT_WIDTH-1:VALUE_WIDTH]);
        c_data_next.low      = mag_full[VALUE_WIDTH-1:0];
        c_data_next.quo      = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= cell_in.valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && cell_in.valid)
        begin
            a_p0_reg   <= a_p0_next;
            a_p1_reg   <= a_p1_next;
            a_meta_reg <= a_meta_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_acc_reg  <= b_acc_next;
            b_meta_reg <= a_meta_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_data_reg <= c_data_next;
        end
    end

    assign dn_valid = c_valid_reg;
    assign dn_data  = c_data_reg;

endmodule

`default_nettype wire

// ----- hdl/tcwf_div_cell.sv -----
// One divider cell: shift in a dividend bit, trial subtract, emit one quotient bit.
`default_nettype none

module tcwf_div_cell
    import tcwf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    output logic      up_ready,
    input  wire div_t up_data,
    output logic      dn_valid,
    input  wire logic dn_ready,
    output div_t      dn_data
);

    logic                 valid_reg;
    div_t                 data_reg;
    div_t                 data_next;
    logic [SUM_WIDTH:0]   trial;
    logic [SUM_WIDTH:0]   diff;
    logic                 fits;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        trial = {up_data.rem, up_data.low[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, up_data.meta.divisor};
        fits  = trial >= {1'b0, up_data.meta.divisor};

        data_next      = up_data;
        data_next.rem  = fits ? diff[SUM_WIDTH-1:0] : trial[SUM_WIDTH-1:0];
        data_next.low  = up_data.low << 1;
        data_next.quo  = {up_data.quo[VALUE_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/tcwf_back.sv -----
// Output stage: restore the quotient sign, pick the fused entry, hold the result beat.
`default_nettype none

module tcwf_back
    import tcwf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    output logic      up_ready,
    input  wire div_t up_data,
    tcwf_out_if.source cell_out
);

    logic                           out_valid_reg;
    logic signed [VALUE_WIDTH-1:0]  fused_value_reg;
    logic signed [WEIGHT_WIDTH-1:0] fused_weight_reg;
    logic signed [VALUE_WIDTH-1:0]  value_next;
    logic [VALUE_WIDTH-1:0]         mean;

    assign up_ready = !out_valid_reg || cell_out.ready;

    always_comb
    begin
        mean       = up_data.meta.neg ? (-up_data.quo) : up_data.quo;
        value_next = up_data.meta.avg ? mean : up_data.meta.res_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            out_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            fused_value_reg  <= value_next;
            fused_weight_reg <= up_data.meta.res_weight;
        end
    end

    assign cell_out.valid        = out_valid_reg;
    assign cell_out.fused_value  = fused_value_reg;
    assign cell_out.fused_weight = fused_weight_reg;

endmodule

`default_nettype wire

// ----- hdl/tsdf_cell_weighted_fusion.sv -----
// TSDF cell fusion: takes one cell beat per cycle while the output is not stalled and returns one
// fused beat per input beat, in order. Beats pass through three front stages (products, weighted
// sum, magnitude), then a chain of VALUE_WIDTH divider cells that each resolve one quotient bit,
// then the output register. The divider chain sets the latency. Every stage has its own valid bit,
// so bubbles close up under back-pressure and a new beat is taken while a finished result waits at
// the output. The weight limit resets to 32767 and is meant to be written only while no beat is in
// flight.
`default_nettype none

module tsdf_cell_weighted_fusion
    import tcwf_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    tcwf_in_if.sink                          cell_in,
    tcwf_out_if.source                       cell_out,
    input  wire logic                        weight_limit_we,
    input  wire logic [MAX_WEIGHT_WIDTH-1:0] weight_limit_wdata
);

    logic [MAX_WEIGHT_WIDTH-1:0] weight_limit_reg;

    logic [VALUE_WIDTH:0] valid_chain;
    logic [VALUE_WIDTH:0] ready_chain;
    div_t                 data_chain [VALUE_WIDTH+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_limit_reg <= MAX_WEIGHT_RESET;
        end
        else if (weight_limit_we)
        begin
            weight_limit_reg <= weight_limit_wdata;
        end
    end

    tcwf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_in      (cell_in),
        .weight_limit (weight_limit_reg),
        .dn_valid     (valid_chain[0]),
        .dn_ready     (ready_chain[0]),
        .dn_data      (data_chain[0])
    );

    for (genvar k = 0; k < VALUE_WIDTH; k++)
    begin : g_cell
        tcwf_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_chain[k]),
            .up_ready (ready_chain[k]),
            .up_data  (data_chain[k]),
            .dn_valid (valid_chain[k+1]),
            .dn_ready (ready_chain[k+1]),
            .dn_data  (data_chain[k+1])
        );
    end

    tcwf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (valid_chain[VALUE_WIDTH]),
        .up_ready (ready_chain[VALUE_WIDTH]),
        .up_data  (data_chain[VALUE_WIDTH]),
        .cell_out (cell_out)
    );

    // A full chain behind a stalled output must push back on the front
    assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_chain) && cell_out.valid && !cell_out.ready) |-> !ready_chain[0])
        else $error("divider chain full and output stalled, yet front sees ready");

    // Averaged items leave the divider with a proper remainder
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_chain[VALUE_WIDTH] && data_chain[VALUE_WIDTH].meta.avg)
            |-> (data_chain[VALUE_WIDTH].rem < data_chain[VALUE_WIDTH].meta.divisor))
        else $error("divider remainder not below divisor");

    // A weighted mean never exceeds the largest magnitude of the value range
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_chain[VALUE_WIDTH] && data_chain[VALUE_WIDTH].meta.avg)
            |-> (data_chain[VALUE_WIDTH].quo <= {1'b1, {(VALUE_WIDTH-1){1'b0}}}))
        else $error("quotient magnitude out of value range");

endmodule

`default_nettype wire

// ----- dv/tsdf_cell_weighted_fusion_test.sv -----
// Self-checking testbench for the TSDF cell fusion block: directed table, then random cells.
`timescale 1ns / 1ps

module tsdf_cell_weighted_fusion_test;
    import tcwf_pkg::*;

    localparam int PIPE_LATENCY     = VALUE_WIDTH + 4;
    localparam int NUM_DIRECTED     = 21;
    localparam int NUM_PHASES       = 8;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int WEIGHT_TOP       = 2 ** (WEIGHT_WIDTH - 1) - 1;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]  old_value;
        logic signed [WEIGHT_WIDTH-1:0] old_weight;
        logic signed [VALUE_WIDTH-1:0]  new_value;
        logic signed [WEIGHT_WIDTH-1:0] meas_weight;
    } cell_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]  fused_value;
        logic signed [WEIGHT_WIDTH-1:0] fused_weight;
    } fused_t;

    typedef struct packed {
        cell_t  stim;
        logic   fixed;
        fused_t want;
    } row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        weight_limit_we;
    logic [MAX_WEIGHT_WIDTH-1:0] weight_limit_wdata;

    tcwf_in_if  cell_in ();
    tcwf_out_if cell_out ();

    tsdf_cell_weighted_fusion u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cell_in            (cell_in),
        .cell_out           (cell_out),
        .weight_limit_we    (weight_limit_we),
        .weight_limit_wdata (weight_limit_wdata)
    );

    // Cells with a fixed result carry it; the rest go through fuse_cell.
    row_t directed_rows [NUM_DIRECTED] = '{
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0}},
        '{'{16'sd123, 16'sd0, -16'sd55, 16'sd0}, 1'b1, '{16'sd123, 16'sd0}},
        '{'{16'sd40, 16'sd0, -16'sd7, 16'sd5}, 1'b1, '{-16'sd7, 16'sd5}},
        '{'{16'sd40, -16'sd3, 16'sd99, -16'sd4}, 1'b1, '{16'sd99, -16'sd4}},
        '{'{16'sd1, 16'sh8000, 16'sd32767, 16'sd32767}, 1'b1, '{16'sd32767, 16'sd32767}},
        '{'{-16'sd9, 16'sd5, 16'sd77, 16'sd0}, 1'b1, '{-16'sd9, 16'sd5}},
        '{'{-16'sd9, 16'sd5, 16'sd77, -16'sd1}, 1'b1, '{-16'sd9, 16'sd5}},
        '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b1, '{16'sd32767, 16'sd32767}},
        '{'{16'sh8000, 16'sd32767, 16'sh8000, 16'sd32767}, 1'b1, '{16'sh8000, 16'sd32767}},
        '{'{16'sd32767, 16'sd32767, 16'sh8000, 16'sd32767}, 1'b0, '{16'sd0, 16'sd0}},
        '{'{16'sd1, 16'sd1, -16'sd2, 16'sd1}, 1'b0, '{16'sd0, 16'sd0}},
        '{'{-16'sd1, 16'sd1, -16'sd1, 16'sd2}, 1'b0, '{16'sd0, 16'sd0}},
        '{'{-16'sd5, 16'sd3, 16'sd0, 16'sd1}, 1'b0, '{16'sd0, 16'sd0}},
        '{'{16'sd3, 16'sh8000, 16'sd4, 16'sh8000}, 1'b1, '{16'sd4, 16'sh8000}},
        '{'{16'sd8, -16'sd1, 16'sd6, 16'sd0}, 1'b1, '{16'sd8, -16'sd1}},
        '{'{16'sd8, 16'sd32767, 16'sd6, 16'sh8000}, 1'b1, '{16'sd8, 16'sd32767}},
        '{'{16'sh8000, 16'sd1, 16'sd32767, 16'sd32767}, 1'b0, '{16'sd0, 16'sd0}},
        '{'{16'sd2, 16'sd0, 16'sh8000, 16'sh8000}, 1'b1, '{16'sh8000, 16'sh8000}},
        '{'{16'sh5555, 16'sh5555, 16'shAAAA, 16'sh2AAA}, 1'b0, '{16'sd0, 16'sd0}},
        '{'{16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh5555}, 1'b1, '{16'sh5555, 16'sh5555}},
        '{'{16'sd1, 16'sd1, 16'sd1, 16'sd1}, 1'b0, '{16'sd0, 16'sd0}}
    };

    logic [MAX_WEIGHT_WIDTH-1:0] weight_cap;
    logic [MAX_WEIGHT_WIDTH-1:0] cap_plan [NUM_PHASES];
    fused_t pending_fused [$];
    int     errors;
    int     beats_checked;
    int     cycles;
    int     burst_left;
    bit     tx_gaps;
    bit     rx_stalls;
    int     n_averaged;
    int     n_replaced;
    int     n_passed;
    logic [15:0] rx_pattern;
    logic [3:0]  rx_slot;

    function automatic fused_t fuse_cell(cell_t c, logic [MAX_WEIGHT_WIDTH-1:0] cap);
        longint ow, nw, wsum, acc, quot;
        fused_t r;
        ow = longint'(c.old_weight);
        nw = longint'(c.meas_weight);
        r.fused_value  = c.old_value;
        r.fused_weight = c.old_weight;
        if (nw > 0 && ow > 0)
        begin
            wsum = ow + nw;
            acc  = longint'(c.old_value) * ow + longint'(c.new_value) * nw;
            quot = acc / wsum;
            if (wsum > longint'(cap))
                wsum = longint'(cap);
            r.fused_value  = quot[VALUE_WIDTH-1:0];
            r.fused_weight = wsum[WEIGHT_WIDTH-1:0];
        end
        else if (nw != 0 && ow <= 0)
        begin
            r.fused_value  = c.new_value;
            r.fused_weight = c.meas_weight;
        end
        return r;
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                1:       return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        return VALUE_WIDTH'($urandom);
    endfunction

    function automatic logic signed [WEIGHT_WIDTH-1:0] pos_weight();
        case ($urandom_range(0, 3))
            0:       return WEIGHT_WIDTH'($urandom_range(1, 8));
            1:       return WEIGHT_WIDTH'($urandom_range(1, 1000));
            2:       return WEIGHT_WIDTH'($urandom_range(1, WEIGHT_TOP));
            default: return WEIGHT_WIDTH'($urandom_range(0, 1) ? WEIGHT_TOP : 1);
        endcase
    endfunction

    function automatic logic signed [WEIGHT_WIDTH-1:0] nonpos_weight();
        if ($urandom_range(0, 3) == 0)
            return '0;
        return WEIGHT_WIDTH'(-int'($urandom_range(1, WEIGHT_TOP + 1)));
    endfunction

    // Mostly averaging cells; the other branches and raw noise fill the rest.
    function automatic cell_t random_cell();
        cell_t c;
        c.old_value = pick_value();
        c.new_value = pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                c.old_weight  = pos_weight();
                c.meas_weight = pos_weight();
            end
            5, 6:
            begin
                c.old_weight  = nonpos_weight();
                c.meas_weight = $urandom_range(0, 1) ? pos_weight() : nonpos_weight();
                if (c.meas_weight == 0)
                    c.meas_weight = pos_weight();
            end
            7:
            begin
                c.old_weight  = pos_weight();
                c.meas_weight = nonpos_weight();
            end
            8:
            begin
                c.old_weight  = nonpos_weight();
                c.meas_weight = '0;
            end
            default:
            begin
                c.old_weight  = WEIGHT_WIDTH'($urandom);
                c.meas_weight = WEIGHT_WIDTH'($urandom);
            end
        endcase
        return c;
    endfunction

    // Enter and leave at a falling edge; valid stays high on return.
    task automatic send_cell(input cell_t c, input logic fixed, input fused_t want);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if (tx_gaps)
            begin
                cell_in.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        cell_in.valid       <= 1'b1;
        cell_in.old_value   <= c.old_value;
        cell_in.old_weight  <= c.old_weight;
        cell_in.new_value   <= c.new_value;
        cell_in.meas_weight <= c.meas_weight;
        do
            @(posedge clk);
        while (!cell_in.ready);
        pending_fused.push_back(fixed ? want : fuse_cell(c, weight_cap));
        if (c.old_weight > 0 && c.meas_weight > 0)
            n_averaged++;
        else if (c.old_weight <= 0 && c.meas_weight != 0)
            n_replaced++;
        else
            n_passed++;
        @(negedge clk);
    endtask

    // Drop valid, drain every pending beat, then let the pipeline go quiet.
    task automatic settle();
        cell_in.valid <= 1'b0;
        while (pending_fused.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    task automatic write_cap(input logic [MAX_WEIGHT_WIDTH-1:0] cap);
        weight_limit_we    <= 1'b1;
        weight_limit_wdata <= cap;
        @(negedge clk);
        weight_limit_we <= 1'b0;
        weight_cap = cap;
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d beats pending", $time, pending_fused.size());
            $display("tsdf_cell_weighted_fusion test failed");
            $finish;
        end
    end

    // Receiver: ready stays high, or with stalls on, walk a random 16-slot pattern reloaded each time it wraps.
    always @(negedge clk)
    begin
        if (!rx_stalls)
            cell_out.ready <= 1'b1;
        else
        begin
            cell_out.ready <= rx_pattern[rx_slot];
            if (rx_slot == 4'd15)
            begin
                rx_slot    <= '0;
                rx_pattern <= 16'($urandom) | 16'h0001;
            end
            else
                rx_slot <= rx_slot + 4'd1;
        end
    end

    always @(posedge clk)
    begin : check_beats
        fused_t want;
        if (rst_n && cell_out.valid && cell_out.ready)
        begin
            if (pending_fused.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat value %0d weight %0d", $time,
                         cell_out.fused_value, cell_out.fused_weight);
            end
            else
            begin
                want = pending_fused.pop_front();
                beats_checked++;
                if (cell_out.fused_value !== want.fused_value)
                begin
                    errors++;
                    $display("%0t: fused_value expected %0d got %0d", $time,
                             want.fused_value, cell_out.fused_value);
                end
                if (cell_out.fused_weight !== want.fused_weight)
                begin
                    errors++;
                    $display("%0t: fused_weight expected %0d got %0d", $time,
                             want.fused_weight, cell_out.fused_weight);
                end
            end
        end
    end

    initial
    begin
        cell_in.valid       = 1'b0;
        cell_in.old_value   = '0;
        cell_in.old_weight  = '0;
        cell_in.new_value   = '0;
        cell_in.meas_weight = '0;
        cell_out.ready      = 1'b0;
        weight_limit_we     = 1'b0;
        weight_limit_wdata  = '0;
        rst_n               = 1'b0;
        weight_cap          = MAX_WEIGHT_RESET;
        errors              = 0;
        beats_checked       = 0;
        cycles              = 0;
        burst_left          = 0;
        n_averaged          = 0;
        n_replaced          = 0;
        n_passed            = 0;
        rx_pattern          = 16'($urandom) | 16'h0001;
        rx_slot             = '0;
        tx_gaps             = 1'b1;
        rx_stalls           = 1'b1;

        // Phase 0 runs on the reset value; phase 2 runs with a limit of zero.
        cap_plan = '{MAX_WEIGHT_RESET, 15'd1, 15'd0, 15'd0, 15'd32767, 15'd2, 15'd300, 15'd0};
        cap_plan[3] = MAX_WEIGHT_WIDTH'($urandom_range(1, 32767));
        cap_plan[7] = MAX_WEIGHT_WIDTH'($urandom_range(3, 2000));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                write_cap(cap_plan[phase]);
            end
            tx_gaps   = (phase % 3 != 1);
            rx_stalls = (phase % 3 != 2) && (phase != 7);
            if (phase == 0)
            begin
                for (int k = 0; k < NUM_DIRECTED; k++)
                    send_cell(directed_rows[k].stim, directed_rows[k].fixed,
                              directed_rows[k].want);
            end
            repeat (RANDOM_PER_PHASE) send_cell(random_cell(), 1'b0, '0);
        end

        settle();
        repeat (PIPE_LATENCY) @(negedge clk);

        $display("checked %0d fused beats over %0d weight limit settings", beats_checked,
                 NUM_PHASES);
        $display("cells averaged %0d, replaced %0d, passed through %0d", n_averaged,
                 n_replaced, n_passed);
        if (errors == 0 && pending_fused.size() == 0)
            $display("tsdf_cell_weighted_fusion test passed");
        else
            $display("tsdf_cell_weighted_fusion test failed");
        $finish;
    end

endmodule
